FILE: src/rne_pkg.sv
package rne_pkg;

	localparam int VALUE_W  = 13;
	localparam int SYM_W    = 7;
	localparam int STEP_W   = 4;
	localparam int MAX_VALID = 4999;

	typedef logic [VALUE_W-1:0] val_t;
	typedef logic [SYM_W-1:0]   sym_t;
	typedef logic [STEP_W-1:0]  step_t;

	// ASCII codes of the numeral characters
	localparam sym_t ASC_NONE = 7'h00;
	localparam sym_t ASC_I    = 7'h49;
	localparam sym_t ASC_V    = 7'h56;
	localparam sym_t ASC_X    = 7'h58;
	localparam sym_t ASC_L    = 7'h4C;
	localparam sym_t ASC_C    = 7'h43;
	localparam sym_t ASC_D    = 7'h44;
	localparam sym_t ASC_M    = 7'h4D;

	// One entry of the descending value table
	typedef struct packed {
		val_t weight;
		sym_t first;
		sym_t second;
		logic pair;
	} step_entry_t;

	// Result of one pass through the compare-subtract unit
	typedef struct packed {
		logic ge;
		val_t diff;
		logic zero;
		sym_t first;
		sym_t second;
		logic pair;
	} step_res_t;

	// Greedy table: 1000 900 500 400 100 90 50 40 10 9 5 4 1
	function automatic step_entry_t step_entry(input step_t idx);
		step_entry_t e;
		e.second = ASC_NONE;
		e.pair   = 1'b0;
		unique case (idx)
			4'd0: begin e.weight = 13'd1000; e.first = ASC_M; end
			4'd1: begin e.weight = 13'd900; e.first = ASC_C; e.second = ASC_M; e.pair = 1'b1; end
			4'd2: begin e.weight = 13'd500; e.first = ASC_D; end
			4'd3: begin e.weight = 13'd400; e.first = ASC_C; e.second = ASC_D; e.pair = 1'b1; end
			4'd4: begin e.weight = 13'd100; e.first = ASC_C; end
			4'd5: begin e.weight = 13'd90; e.first = ASC_X; e.second = ASC_C; e.pair = 1'b1; end
			4'd6: begin e.weight = 13'd50; e.first = ASC_L; end
			4'd7: begin e.weight = 13'd40; e.first = ASC_X; e.second = ASC_L; e.pair = 1'b1; end
			4'd8: begin e.weight = 13'd10; e.first = ASC_X; end
			4'd9: begin e.weight = 13'd9; e.first = ASC_I; e.second = ASC_X; e.pair = 1'b1; end
			4'd10: begin e.weight = 13'd5; e.first = ASC_V; end
			4'd11: begin e.weight = 13'd4; e.first = ASC_I; e.second = ASC_V; e.pair = 1'b1; end
			default: begin e.weight = 13'd1; e.first = ASC_I; end
		endcase
		return e;
	endfunction

endpackage

FILE: src/rne_step_unit.sv
module rne_step_unit
	import rne_pkg::*;
(
	input  val_t      rem,
	input  step_t     idx,
	output step_res_t res
);

	step_entry_t        ent;
	logic [VALUE_W:0]   sub;

	// table lookup, then one compare-subtract against the current weight
	always_comb begin
		ent       = step_entry(idx);
		sub       = {1'b0, rem} - {1'b0, ent.weight};
		res.ge    = ~sub[VALUE_W];
		res.diff  = sub[VALUE_W-1:0];
		res.zero  = (sub[VALUE_W-1:0] == '0);
		res.first = ent.first;
		res.second = ent.second;
		res.pair  = ent.pair;
	end

endmodule

FILE: src/roman_numeral_encoder_core.sv
// After an item is accepted and registered, the scan gives one character per cycle while
// the table entry matches; each entry the scan skips holds the output back. A number
// is encoded by the one compare-subtract unit that walks the 13-entry table.
// Out-of-range values give their single flagged result in the cycle after accept, busy stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops strobe.
module roman_numeral_encoder_core
	import rne_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  val_t       value,
	output logic       strobe,
	output sym_t       symbol,
	output logic       last,
	output logic       invalid
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_PAIR = 2'd2;

	logic [1:0] state_q;
	val_t       rem_q;
	step_t      idx_q;
	sym_t       sec_q;
	logic       strobe_q;
	sym_t       symbol_q;
	logic       last_q;
	logic       invalid_q;
	step_res_t  res;
	logic       accept;
	logic       in_range;

	rne_step_unit u_step (
		.rem (rem_q),
		.idx (idx_q),
		.res (res)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign in_range = (value != '0) && (value <= val_t'(MAX_VALID));

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rem_q <= value;
						idx_q <= '0;
						if (in_range) begin
							state_q <= ST_RUN;
						end else begin
							strobe_q  <= 1'b1;
							symbol_q  <= ASC_NONE;
							last_q    <= 1'b1;
							invalid_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (res.ge) begin
						rem_q     <= res.diff;
						strobe_q  <= 1'b1;
						symbol_q  <= res.first;
						last_q    <= ~res.pair & res.zero;
						invalid_q <= 1'b0;
						sec_q     <= res.second;
						if (res.pair) begin
							state_q <= ST_PAIR;
						end else if (res.zero) begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PAIR: begin
					// second character of a subtractive form
					strobe_q  <= 1'b1;
					symbol_q  <= sec_q;
					last_q    <= (rem_q == '0);
					invalid_q <= 1'b0;
					idx_q     <= idx_q + 1'b1;
					state_q   <= (rem_q == '0) ? ST_IDLE : ST_RUN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe  = strobe_q;
	assign symbol  = symbol_q;
	assign last    = last_q;
	assign invalid = invalid_q;

	// a scan in progress always has something left to encode
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rem_q != '0)
		else $error("scan running with nothing left");

	// the closing character of a numeral leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q && !invalid_q |-> state_q == ST_IDLE)
		else $error("last character while still busy");

	// an invalid result is always alone and blank
	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && invalid_q |-> last_q && symbol_q == ASC_NONE)
		else $error("invalid result not single");

	// a valid character is never blank
	a_valid_sym: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !invalid_q |-> symbol_q != ASC_NONE)
		else $error("blank character on valid item");

endmodule

FILE: sim/roman_numeral_encoder_core_test.sv
`timescale 1ns / 100ps

module roman_numeral_encoder_core_test;
	import rne_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	// one character of a numeral as it appears on the result ports
	typedef struct packed {
		sym_t symbol;
		logic last;
		logic invalid;
	} numeral_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	val_t value = '0;
	logic strobe;
	sym_t symbol;
	logic last;
	logic invalid;

	numeral_char_t pending_chars[$];
	sym_t numeral_buf[$];
	bit gaps_on = 1'b1;
	int numbers_sent = 0;
	int out_of_range_sent = 0;
	int chars_checked = 0;
	int errors = 0;
	int cycle_count = 0;

	roman_numeral_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.symbol(symbol),
		.last(last),
		.invalid(invalid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one decimal digit with its unit, five and ten symbols
	task automatic add_decimal_digit(input int d, input sym_t one, input sym_t five,
			input sym_t ten);
		int k;
		case (d)
			4: begin
				numeral_buf.push_back(one);
				numeral_buf.push_back(five);
			end
			9: begin
				numeral_buf.push_back(one);
				numeral_buf.push_back(ten);
			end
			default: begin
				if (d >= 5)
					numeral_buf.push_back(five);
				for (k = 0; k < d % 5; k++)
					numeral_buf.push_back(one);
			end
		endcase
	endtask

	// expected characters for one number, queued in output order
	task automatic encode_numeral(input val_t v);
		int n;
		int k;
		numeral_char_t c;
		n = int'(v);
		numeral_buf.delete();
		if (n == 0 || n > MAX_VALID) begin
			c.symbol = ASC_NONE;
			c.last = 1'b1;
			c.invalid = 1'b1;
			pending_chars.push_back(c);
			out_of_range_sent++;
		end else begin
			for (k = 0; k < n / 1000; k++)
				numeral_buf.push_back(ASC_M);
			add_decimal_digit((n / 100) % 10, ASC_C, ASC_D, ASC_M);
			add_decimal_digit((n / 10) % 10, ASC_X, ASC_L, ASC_C);
			add_decimal_digit(n % 10, ASC_I, ASC_V, ASC_X);
			for (k = 0; k < numeral_buf.size(); k++) begin
				c.symbol = numeral_buf[k];
				c.last = (k == numeral_buf.size() - 1);
				c.invalid = 1'b0;
				pending_chars.push_back(c);
			end
		end
	endtask

	task automatic report_error(input string what);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// offer one number, hold it until accepted, then queue its prediction
	task automatic send_number(input val_t v);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		encode_numeral(v);
		numbers_sent++;
	endtask

	// result checker: every strobe must match the oldest expected character
	always @(posedge clk) begin : check_chars
		numeral_char_t e;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report_error($sformatf("unexpected character sym=%h last=%b inv=%b",
					symbol, last, invalid));
			end else begin
				e = pending_chars.pop_front();
				chars_checked++;
				if (symbol !== e.symbol || last !== e.last || invalid !== e.invalid)
					report_error($sformatf(
						"exp sym=%h last=%b inv=%b, got sym=%h last=%b inv=%b",
						e.symbol, e.last, e.invalid, symbol, last, invalid));
			end
		end
	end

	// extremes of the range and of the numeral length
	task automatic test_extremes();
		send_number(13'd1);
		send_number(13'd4999);
		send_number(13'd4888);
		send_number(13'd3999);
		send_number(13'd4000);
		send_number(13'd0);
		send_number(13'd5000);
		send_number(13'd8191);
	endtask

	// each subtractive pair and each repeated-unit form
	task automatic test_digit_forms();
		send_number(13'd4);
		send_number(13'd9);
		send_number(13'd14);
		send_number(13'd40);
		send_number(13'd90);
		send_number(13'd400);
		send_number(13'd900);
		send_number(13'd494);
		send_number(13'd949);
		send_number(13'd2444);
		send_number(13'd1666);
		send_number(13'd2777);
	endtask

	// out-of-range numbers back to back, busy should stay low
	task automatic test_invalid_burst();
		gaps_on = 1'b0;
		send_number(13'd0);
		send_number(13'd6000);
		send_number(13'd0);
		send_number(13'd4096);
		send_number(13'd5001);
		gaps_on = 1'b1;
	endtask

	// mostly valid numbers, some small ones, some out of range
	task automatic test_random_numbers(input int count, input bit with_gaps);
		int i;
		val_t v;
		gaps_on = with_gaps;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: v = val_t'($urandom_range(1, MAX_VALID));
				7: v = val_t'($urandom_range(1, 49));
				8: v = val_t'($urandom_range(MAX_VALID + 1, 8191));
				default: v = '0;
			endcase
			send_number(v);
		end
	endtask

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d characters still expected",
			cycle_count, pending_chars.size());
		$display("** roman_numeral_encoder_core: FAILED **");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_digit_forms();
		test_invalid_burst();
		test_random_numbers(55, 1'b1);
		test_random_numbers(20, 1'b0);

		start <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d numbers converted (%0d out of range), %0d characters checked",
			numbers_sent, out_of_range_sent, chars_checked);
		$display("%0d mismatches in %0d cycles", errors, cycle_count);
		if (errors == 0)
			$display("** roman_numeral_encoder_core: PASSED **");
		else
			$display("** roman_numeral_encoder_core: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
src/rne_pkg.sv
src/rne_step_unit.sv
src/roman_numeral_encoder_core.sv
sim/roman_numeral_encoder_core_test.sv
